// ===== hdl/crs_pkg.sv =====
`timescale 1ns / 1ps

package crs_pkg;

  // Default number of stack levels, base level included
  localparam int unsigned StackDepthDef = 64;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DepthW = 6;
  localparam int unsigned CfgIdxW = 2;

  // Operation codes
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SCREEN_LEFT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_TOP    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_RIGHT  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
  } rect_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [CoordW-1:0] new_left;
    logic signed [CoordW-1:0] new_top;
    logic signed [CoordW-1:0] new_right;
    logic signed [CoordW-1:0] new_bottom;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cur_left;
    logic signed [CoordW-1:0] cur_top;
    logic signed [CoordW-1:0] cur_right;
    logic signed [CoordW-1:0] cur_bottom;
    logic [DepthW-1:0]        depth;
    logic                     ignored;
  } out_item_t;

  // Shift control handed to each cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ===== hdl/crs_cell.sv =====
`timescale 1ns / 1ps

module crs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crs_pkg::shift_t ctrl_i,
  input  crs_pkg::rect_t  prev_i,
  input  crs_pkg::rect_t  next_i,
  output crs_pkg::rect_t  rect_o
);

  crs_pkg::rect_t rect_d, rect_q;

  // Take the upper neighbour on push, the lower one on pop, else hold
  always_comb begin
    rect_d = rect_q;
    if (ctrl_i.push) begin
      rect_d = prev_i;
    end else if (ctrl_i.pop) begin
      rect_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q <= '0;
    end else begin
      rect_q <= rect_d;
    end
  end

  assign rect_o = rect_q;

endmodule

// ===== hdl/clip_rectangle_stack.sv =====
`timescale 1ns / 1ps
// Clip rectangle stack built as a chain of shifting cells; cell 0 is the current clip.
// The result strobe rises in the cycle after start is taken.
// Throughput: one item per cycle, set by the shift of the cell chain.
// Results cannot be stalled; busy_o is always low.
// Reset: stack at base, current clip and screen registers zero, no result pending.
module clip_rectangle_stack #(
  parameter int unsigned STACK_DEPTH = crs_pkg::StackDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  crs_pkg::in_item_t           item_i,
  output logic                        done_o,
  output crs_pkg::out_item_t          result_o,
  input  logic                        cfg_we_i,
  input  logic [crs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [crs_pkg::CoordW-1:0]  cfg_data_i
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH);
  localparam int unsigned NumCells = STACK_DEPTH - 1;

  // Screen range registers
  crs_pkg::rect_t base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crs_pkg::REG_SCREEN_LEFT:   base_q.left   <= cfg_data_i;
        crs_pkg::REG_SCREEN_TOP:    base_q.top    <= cfg_data_i;
        crs_pkg::REG_SCREEN_RIGHT:  base_q.right  <= cfg_data_i;
        crs_pkg::REG_SCREEN_BOTTOM: base_q.bottom <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode the item
  logic [SpW-1:0] sp_d, sp_q;
  logic           ign_d, ign_q;
  logic           valid_q;
  logic           accept, is_push, is_pop, do_push, do_pop, do_rst, full;

  assign busy_o  = 1'b0;
  assign accept  = start_i;
  assign full    = (sp_q == SpW'(STACK_DEPTH - 1));
  assign is_push = accept && (item_i.func == crs_pkg::FUNC_PUSH);
  assign is_pop  = accept && (item_i.func == crs_pkg::FUNC_POP);
  assign do_push = is_push && !full;
  assign do_pop  = is_pop && (sp_q != '0);
  assign do_rst  = accept && (item_i.func == crs_pkg::FUNC_RESET);

  // Cell values, with the base rectangle below the last cell
  crs_pkg::rect_t cell_val [NumCells+1];
  crs_pkg::rect_t isect, pop_src;

  assign cell_val[NumCells] = base_q;

  // Intersect the pushed rectangle with the current clip
  always_comb begin
    isect.left   = (item_i.new_left > cell_val[0].left) ? item_i.new_left : cell_val[0].left;
    isect.top    = (item_i.new_top > cell_val[0].top) ? item_i.new_top : cell_val[0].top;
    isect.right  = (item_i.new_right < cell_val[0].right) ? item_i.new_right
                                                          : cell_val[0].right;
    isect.bottom = (item_i.new_bottom < cell_val[0].bottom) ? item_i.new_bottom
                                                            : cell_val[0].bottom;
  end

  // Returning to the base level reads the screen registers as they are now
  assign pop_src = (do_rst || (sp_q == SpW'(1))) ? base_q : cell_val[1];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    crs_pkg::shift_t ctrl;
    crs_pkg::rect_t  prev, next;

    if (i == 0) begin : g_head
      assign ctrl.push = do_push;
      assign ctrl.pop  = do_pop || do_rst;
      assign prev      = isect;
      assign next      = pop_src;
    end else begin : g_body
      assign ctrl.push = do_push;
      assign ctrl.pop  = do_pop;
      assign prev      = cell_val[i-1];
      assign next      = cell_val[i+1];
    end

    crs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev),
      .next_i (next),
      .rect_o (cell_val[i])
    );
  end

  // Advance the stack pointer and flag ignored items
  always_comb begin
    sp_d  = sp_q;
    ign_d = 1'b0;
    if (do_push) begin
      sp_d = sp_q + SpW'(1);
    end else if (do_pop) begin
      sp_d = sp_q - SpW'(1);
    end else if (do_rst) begin
      sp_d = '0;
    end
    if ((is_push && full) || (is_pop && (sp_q == '0))) begin
      ign_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= '0;
      ign_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sp_q    <= sp_d;
      valid_q <= accept;
      if (accept) begin
        ign_q <= ign_d;
      end
    end
  end

  // Show the state left by the last item
  assign done_o              = valid_q;
  assign result_o.cur_left   = cell_val[0].left;
  assign result_o.cur_top    = cell_val[0].top;
  assign result_o.cur_right  = cell_val[0].right;
  assign result_o.cur_bottom = cell_val[0].bottom;
  assign result_o.depth      = crs_pkg::DepthW'(sp_q);
  assign result_o.ignored    = ign_q;

endmodule
